@@ rtl/spv_pkg.sv @@
// ----------------------------------------------------------------------------
// spv_pkg: shared types and helpers for the 3x3 peak vote block
// Pixel column and result structs, window control bundle, min/max helpers.
// ----------------------------------------------------------------------------
package spv_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned CNT_W  = 2;
  localparam logic [CNT_W-1:0] COLS_FULL = 2'd2;
  localparam logic [PIX_W-1:0] VOTE_MAX  = 8'hFF;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bottom;
  } column_t;

  typedef struct packed {
    logic shift;      // load a new column into the window
    logic row_start;  // column is the left padding column of a row
  } win_ctrl_t;

  typedef struct packed {
    pixel_t new_vote;
    logic   star_hit;
    pixel_t contrast;
  } result_t;

  function automatic pixel_t max8(input pixel_t a, input pixel_t b);
    max8 = (a > b) ? a : b;
  endfunction

  function automatic pixel_t min8(input pixel_t a, input pixel_t b);
    min8 = (a < b) ? a : b;
  endfunction

endpackage

@@ rtl/star_peak_vote_3x3.sv @@
// ----------------------------------------------------------------------------
// star_peak_vote_3x3: streaming 3x3 local-maximum detector with vote counting
// Input reg -> window + kernel -> result reg, one column/clock if unstalled.
// ----------------------------------------------------------------------------
// Usage: feed one pixel column (top/mid/bottom) per input transaction, with
// row_start high on the left padding column of each row. The block keeps the
// two previous columns; the window centre is the previous column's mid pixel.
// old_vote must carry the vote byte of that centre column (one to the left of
// the incoming column). The first two columns of a row produce no output
// transaction; each later column produces exactly one. Throughput is one
// column per clock, sustained while out_ready stays high. A column leaves the
// input register only when the result register is free or being emptied in
// the same cycle, even if that column gives no result; so while a result is
// held (out_valid high, out_ready low) the input register still takes one
// column, and in_ready then stays low until the result is taken. The result
// of an accepted column is written from the input register into the result
// register, which raises out_valid; a held result stalls it on the way.
// contrast_threshold is written through cfg_write_en / cfg_write_data and
// should only change when idle.
// ----------------------------------------------------------------------------
module star_peak_vote_3x3 (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] top_pixel,
  input  logic [7:0] mid_pixel,
  input  logic [7:0] bottom_pixel,
  input  logic [7:0] old_vote,
  input  logic       row_start,
  // output channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] new_vote,
  output logic       star_hit,
  output logic [7:0] contrast,
  // configuration
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data
);

  // input register stage
  logic              s1_valid;
  spv_pkg::column_t  s1_col;
  spv_pkg::pixel_t   s1_old_vote;
  logic              s1_row_start;
  logic              s1_go;      // s1 contents consumed this cycle
  logic              emit;       // s1 produces a result this cycle

  spv_pkg::pixel_t   threshold;
  spv_pkg::win_ctrl_t win_ctrl;
  spv_pkg::column_t  left_col, centre_col;
  logic              win_full;
  spv_pkg::result_t  kern_res;
  spv_pkg::result_t  out_res;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign emit     = s1_go && !s1_row_start && win_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_col.top    <= top_pixel;
      s1_col.mid    <= mid_pixel;
      s1_col.bottom <= bottom_pixel;
      s1_old_vote   <= old_vote;
      s1_row_start  <= row_start;
    end
  end

  spv_top_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .threshold      (threshold)
  );

  // window slides on every column that leaves the input register
  assign win_ctrl = '{shift: s1_go, row_start: s1_row_start};

  spv_window u_window (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (win_ctrl),
    .col_in     (s1_col),
    .left_col   (left_col),
    .centre_col (centre_col),
    .full       (win_full)
  );

  spv_kernel u_kernel (
    .left_col   (left_col),
    .centre_col (centre_col),
    .right_col  (s1_col),
    .old_vote   (s1_old_vote),
    .threshold  (threshold),
    .result     (kern_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= kern_res;
    end
  end

  assign new_vote = out_res.new_vote;
  assign star_hit = out_res.star_hit;
  assign contrast = out_res.contrast;

  // a hit always means contrast cleared the threshold
  a_hit_contrast: assert property (@(posedge clk) disable iff (rst)
    out_valid && star_hit |-> contrast > threshold)
    else $error("star_hit without contrast above threshold");

  // a hit never leaves the vote at zero
  a_hit_vote: assert property (@(posedge clk) disable iff (rst)
    out_valid && star_hit |-> new_vote != 8'd0)
    else $error("vote not incremented on hit");

  // a row start leaves the window one column deep
  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_row_start |=> !win_full)
    else $error("window full right after row start");

  // a stalled input register keeps its column
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_col))
    else $error("input register lost data while stalled");

endmodule

@@ rtl/spv_window.sv @@
// ----------------------------------------------------------------------------
// spv_window: two-column history of the 3x3 window
// Holds the older (left) and newer (centre) column and the fill count.
// ----------------------------------------------------------------------------
module spv_window (
  input  logic               clk,
  input  logic               rst,
  input  spv_pkg::win_ctrl_t ctrl,
  input  spv_pkg::column_t   col_in,
  output spv_pkg::column_t   left_col,
  output spv_pkg::column_t   centre_col,
  output logic               full
);

  logic [spv_pkg::CNT_W-1:0] cols_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_col   <= '0;
      centre_col <= '0;
      cols_seen  <= '0;
    end else if (ctrl.shift) begin
      left_col   <= centre_col;
      centre_col <= col_in;
      if (ctrl.row_start) begin
        cols_seen <= spv_pkg::CNT_W'(1);
      end else if (cols_seen != spv_pkg::COLS_FULL) begin
        cols_seen <= cols_seen + spv_pkg::CNT_W'(1);
      end
    end
  end

  assign full = (cols_seen == spv_pkg::COLS_FULL);

endmodule

@@ rtl/spv_kernel.sv @@
// ----------------------------------------------------------------------------
// spv_kernel: 3x3 peak test, contrast and vote update
// Pure combinational; the window centre is the centre column's mid pixel.
// ----------------------------------------------------------------------------
module spv_kernel (
  input  spv_pkg::column_t left_col,
  input  spv_pkg::column_t centre_col,
  input  spv_pkg::column_t right_col,
  input  spv_pkg::pixel_t  old_vote,
  input  spv_pkg::pixel_t  threshold,
  output spv_pkg::result_t result
);

  spv_pkg::pixel_t left_max, left_min, right_max, right_min;
  spv_pkg::pixel_t win_max, nbr_min, centre;

  always_comb begin
    centre    = centre_col.mid;
    left_max  = spv_pkg::max8(spv_pkg::max8(left_col.top, left_col.mid), left_col.bottom);
    left_min  = spv_pkg::min8(spv_pkg::min8(left_col.top, left_col.mid), left_col.bottom);
    right_max = spv_pkg::max8(spv_pkg::max8(right_col.top, right_col.mid), right_col.bottom);
    right_min = spv_pkg::min8(spv_pkg::min8(right_col.top, right_col.mid), right_col.bottom);

    win_max  = spv_pkg::max8(spv_pkg::max8(left_max, right_max),
                             spv_pkg::max8(spv_pkg::max8(centre_col.top, centre_col.bottom),
                                           centre));
    // ring excludes the centre pixel itself
    nbr_min  = spv_pkg::min8(spv_pkg::min8(left_min, right_min),
                             spv_pkg::min8(centre_col.top, centre_col.bottom));

    result.contrast = (centre > nbr_min) ? (centre - nbr_min) : '0;
    result.star_hit = (centre == win_max) && (result.contrast > threshold);
    result.new_vote = (old_vote == spv_pkg::VOTE_MAX) ? old_vote
                    : old_vote + spv_pkg::pixel_t'(result.star_hit);
  end

endmodule

@@ rtl/spv_top_regs.sv @@
// ----------------------------------------------------------------------------
// spv_top_regs: configuration register for the contrast threshold
// Written with write enable, no read-back.
// ----------------------------------------------------------------------------
module spv_top_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_en,
  input  spv_pkg::pixel_t cfg_write_data,
  output spv_pkg::pixel_t threshold
);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_write_en) begin
      threshold <= cfg_write_data;
    end
  end

endmodule
